// ----- rtl/windowed_fft_log_spectrogram_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the log spectrogram block
// Concurrent property shorthands clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_FFT_LOG_SPECTROGRAM_ASSERT_SVH
`define WINDOWED_FFT_LOG_SPECTROGRAM_ASSERT_SVH

// same-cycle implication
`define WFLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfls: same-cycle property failed");

// next-cycle implication
`define WFLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfls: next-cycle property failed");

`endif

// ----- rtl/wfls_pkg.sv -----
// ---------------------------------------------------------------------------
// wfls_pkg
// Shared constants, state types and window/twiddle tables.
// ---------------------------------------------------------------------------
`default_nettype none

package wfls_pkg;

    localparam int WIN_LEN      = 64;
    localparam int WIN_AW       = 6;
    localparam int NUM_BINS     = 32;
    localparam int BIN_W        = 5;
    localparam int SAMPLE_W     = 16;
    localparam int WS_W         = 17;
    localparam int MAC_W        = 33;
    localparam int ACC_W        = 40;
    localparam int MAG_W        = 23;
    localparam int PW           = 48;
    localparam int EXP_W        = 6;
    localparam int FRAC_W       = 16;
    localparam int FRAC_AW      = 4;
    localparam int LG_W         = EXP_W + FRAC_W;
    localparam int MANT_W       = 31;
    localparam int DB_W         = 15;
    localparam int DBP_W        = 48;
    localparam int OUT_DATA_W   = 40;
    localparam int OVL_W        = 6;
    localparam int HOP_W        = 7;
    localparam int CORDIC_STEPS = 24;
    localparam int HANN_DIV     = WIN_LEN - 1;

    localparam logic [25:0]    DB_PER_LOG2   = 26'd50504453;
    localparam longint         CORDIC_GAIN   = 64'sd652032875;
    localparam logic [OVL_W-1:0] OVERLAP_RESET = 6'd32;
    localparam logic           REG_OVERLAP   = 1'b0;

    typedef logic [WIN_LEN-1:0][15:0] q15_tab_t;

    localparam logic [0:CORDIC_STEPS-1][31:0] ATAN_TURNS = {
        32'd536870912, 32'd316933406, 32'd167458908, 32'd85004756,
        32'd42667340,  32'd21354465,  32'd10679837,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_TAIL, ST_WIN_RD, ST_WIN_MUL, ST_WIN_WR,
        ST_BIN, ST_MAC_COS, ST_MAC_SIN, ST_MAC_ACC, ST_RND, ST_SQ_RE,
        ST_SQ_IM, ST_SUM, ST_LOG, ST_EMIT, ST_FINISH
    } top_state_t;

    typedef enum logic [2:0] {
        LG_IDLE, LG_NORM, LG_SQR, LG_MUL, LG_DONE
    } log_state_t;

    // cos (sel=0) or sin (sel=1) of phase/2^32 turns, Q1.30
    function automatic longint cordic_cs(input logic [31:0] phase, input logic sel);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint c;
        longint s;
        begin
            x = CORDIC_GAIN;
            y = 0;
            z = longint'({34'd0, phase[29:0]});
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TURNS[k]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TURNS[k]);
                end
            end
            case (phase[31:30])
                2'd0:    begin c = x;  s = y;  end
                2'd1:    begin c = -y; s = x;  end
                2'd2:    begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
            return sel ? s : c;
        end
    endfunction

    function automatic logic [15:0] sat_q15(input longint v);
        begin
            if (v > 32767)
                return 16'h7FFF;
            if (v < -32768)
                return 16'h8000;
            return v[15:0];
        end
    endfunction

    function automatic q15_tab_t hann_table();
        q15_tab_t t;
        logic [63:0] ph;
        longint c;
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                ph = ((64'(i) << 32) + 64'(HANN_DIV / 2)) / HANN_DIV;
                c = cordic_cs(ph[31:0], 1'b0);
                t[i] = sat_q15(((64'sd1 << 30) - c + (64'sd1 << 15)) >>> 16);
            end
            return t;
        end
    endfunction

    function automatic q15_tab_t twiddle_table(input logic sel);
        q15_tab_t t;
        logic [63:0] ph;
        longint v;
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                ph = ((64'(i) << 32) + 64'(WIN_LEN / 2)) / WIN_LEN;
                v = cordic_cs(ph[31:0], sel);
                t[i] = sat_q15((v + (64'sd1 << 14)) >>> 15);
            end
            return t;
        end
    endfunction

    localparam q15_tab_t HANN_TAB = hann_table();
    localparam q15_tab_t COS_TAB  = twiddle_table(1'b0);
    localparam q15_tab_t SIN_TAB  = twiddle_table(1'b1);

endpackage

`default_nettype wire

// ----- rtl/wfls_log2db.sv -----
// ---------------------------------------------------------------------------
// wfls_log2db
// Integer power to 1/256 dB: serial normalize, 16 squaring steps, scale.
// ---------------------------------------------------------------------------
`default_nettype none

module wfls_log2db (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wfls_pkg::PW-1:0]    power,
    output logic                       done,
    output logic [wfls_pkg::DB_W-1:0]  db,
    output logic                       no_energy
);
    import wfls_pkg::*;

    log_state_t              state_reg, state_next;
    logic [PW-1:0]           norm_reg, norm_next;
    logic [EXP_W-1:0]        exp_reg, exp_next;
    logic [MANT_W-1:0]       mant_reg, mant_next;
    logic [FRAC_W-1:0]       frac_reg, frac_next;
    logic [FRAC_AW-1:0]      bit_reg, bit_next;
    logic [DBP_W-1:0]        dbp_reg, dbp_next;
    logic                    zero_reg, zero_next;
    logic [2*MANT_W-1:0]     sq;
    logic [MANT_W:0]         sq_hi;
    logic [DBP_W:0]          dbp_rnd;
    logic [DBP_W-32:0]       db_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LG_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        exp_reg  <= exp_next;
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        bit_reg  <= bit_next;
        dbp_reg  <= dbp_next;
        zero_reg <= zero_next;
    end

    assign sq    = mant_reg * mant_reg;
    assign sq_hi = sq[2*MANT_W-1:MANT_W-1];

    always_comb
    begin
        state_next = state_reg;
        norm_next  = norm_reg;
        exp_next   = exp_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        bit_next   = bit_reg;
        dbp_next   = dbp_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    norm_next = power;
                    exp_next  = EXP_W'(PW - 1);
                    zero_next = (power == '0);
                    state_next = (power == '0) ? LG_DONE : LG_NORM;
                end
            end
            LG_NORM:
            begin
                if (norm_reg[PW-1])
                begin
                    mant_next  = norm_reg[PW-1 -: MANT_W];
                    frac_next  = '0;
                    bit_next   = FRAC_AW'(FRAC_W - 1);
                    state_next = LG_SQR;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    exp_next  = exp_reg - 1'b1;
                end
            end
            LG_SQR:
            begin
                if (sq_hi[MANT_W])
                begin
                    frac_next[bit_reg] = 1'b1;
                    mant_next = sq_hi[MANT_W:1];
                end
                else
                    mant_next = sq_hi[MANT_W-1:0];
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = LG_MUL;
            end
            LG_MUL:
            begin
                dbp_next   = DBP_W'({exp_reg, frac_reg}) * DBP_W'(DB_PER_LOG2);
                state_next = LG_DONE;
            end
            LG_DONE:
                state_next = LG_IDLE;
            default:
                state_next = LG_IDLE;
        endcase
    end

    assign dbp_rnd   = {1'b0, dbp_reg} + (49'd1 << 31);
    assign db_wide   = dbp_rnd[DBP_W:32];
    assign done      = (state_reg == LG_DONE);
    assign no_energy = zero_reg;
    assign db        = zero_reg ? '0 :
                       (db_wide > 17'd32767) ? 15'h7FFF : db_wide[DB_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/windowed_fft_log_spectrogram.sv -----
// ---------------------------------------------------------------------------
// windowed_fft_log_spectrogram
// Streaming Hann-windowed 64-point DFT, 32 bins of log power per frame.
// ---------------------------------------------------------------------------
// Samples are taken one per request; a sample that completes no frame is
// checked and the block returns to idle. A frame is a window pass over the
// sample ring, then per bin a setup step, a multiply-accumulate pass through
// the single read port of the workspace memory, rounding and squaring, log
// conversion and an emit step, plus any output stall. A finished bin sits in
// the output register while the next bin is computed; the block takes a new
// sample once the last bin of its frames is in the output register.
`default_nettype none

module windowed_fft_log_spectrogram (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // end_of_signal
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] frame_number, [21:16] bin_index,
                                   // [36:22] power_db, [39:37] zero
    output logic        m_tlast,   // frame_last
    output logic [1:0]  m_tuser,   // [0] no_energy, [1] signal_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wfls_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << 14);
    localparam logic signed [32:0]      WIN_HALF = 33'(1 << 14);

    top_state_t              state_reg, state_next;
    logic [OVL_W-1:0]        overlap_reg;
    logic [31:0]             seen_reg, seen_next;
    logic [31:0]             nfs_reg, nfs_next;
    logic [15:0]             frames_reg, frames_next;
    logic                    eos_reg, eos_next;
    logic [1:0]              fcnt_reg, fcnt_next;
    logic                    tail_reg, tail_next;
    logic                    final_reg, final_next;
    logic                    out_valid_reg, out_valid_next;

    logic [HOP_W-1:0]        avail_reg, avail_next;
    logic [WIN_AW-1:0]       n_reg, n_next;
    logic [BIN_W-1:0]        k_reg, k_next;
    logic [WIN_AW-1:0]       idx_reg, idx_next;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0] acc_im_reg, acc_im_next;
    logic signed [MAC_W-1:0] prod_reg, prod_next;
    logic signed [31:0]      wprod_reg, wprod_next;
    logic [MAG_W-1:0]        re_abs_reg, re_abs_next;
    logic [MAG_W-1:0]        im_abs_reg, im_abs_next;
    logic [PW-1:0]           sq_re_reg, sq_re_next;
    logic [PW-1:0]           sq_im_reg, sq_im_next;
    logic [DB_W-1:0]         db_reg, db_next;
    logic                    ne_reg, ne_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;
    logic [1:0]              out_user_reg, out_user_next;

    logic [SAMPLE_W-1:0]     ring_mem [WIN_LEN];
    logic [SAMPLE_W-1:0]     ring_q_reg;
    logic [WIN_AW-1:0]       ring_raddr;
    logic [WS_W-1:0]         ws_mem [WIN_LEN];
    logic [WS_W-1:0]         ws_q_reg;
    logic [WIN_AW-1:0]       ws_raddr;
    logic                    ws_we;
    logic [WS_W-1:0]         ws_wdata;

    logic                    in_acc;
    logic                    cfg_we;
    logic                    out_free;
    logic [31:0]             lag;
    logic                    dist_ge_win;
    logic [HOP_W-1:0]        dist7;
    logic [HOP_W-1:0]        hop;
    logic                    log_start;
    logic [PW-1:0]           log_power;
    logic                    log_done;
    logic [DB_W-1:0]         log_db;
    logic                    log_zero;
    logic signed [ACC_W-1:0] re_biased;
    logic signed [ACC_W-1:0] im_biased;
    logic signed [ACC_W-1:0] re_rnd;
    logic signed [ACC_W-1:0] im_rnd;
    logic signed [ACC_W-1:0] re_mag;
    logic signed [ACC_W-1:0] im_mag;
    logic signed [32:0]      wbiased;
    logic signed [32:0]      wrnd;

    assign in_acc      = s_tvalid && s_tready;
    assign cfg_we      = psel && penable && pwrite && pready && (paddr[2] == REG_OVERLAP);
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_OVERLAP) ? {26'd0, overlap_reg} : 32'd0;
    assign out_free    = !out_valid_reg || m_tready;
    assign lag         = seen_reg - nfs_reg;
    assign dist_ge_win = |lag[31:WIN_AW];
    assign dist7       = lag[HOP_W-1:0];
    assign hop         = HOP_W'(WIN_LEN) - HOP_W'(overlap_reg);
    assign s_tready    = (state_reg == ST_IDLE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign re_biased = acc_re_reg + ACC_HALF;
    assign im_biased = acc_im_reg + ACC_HALF;
    assign re_rnd    = re_biased >>> 15;
    assign im_rnd    = im_biased >>> 15;
    assign re_mag    = re_rnd[ACC_W-1] ? -re_rnd : re_rnd;
    assign im_mag    = im_rnd[ACC_W-1] ? -im_rnd : im_rnd;
    assign wbiased   = 33'(wprod_reg) + WIN_HALF;
    assign wrnd      = wbiased >>> 15;

    assign ring_raddr = nfs_reg[WIN_AW-1:0] + n_reg;
    assign ws_we      = (state_reg == ST_WIN_WR);
    assign ws_wdata   = (HOP_W'(n_reg) < avail_reg) ? wrnd[WS_W-1:0] : '0;
    assign log_start  = (state_reg == ST_SUM);
    assign log_power  = sq_re_reg + sq_im_reg;

    always_comb
    begin
        case (state_reg)
            ST_BIN:                 ws_raddr = '0;
            ST_MAC_SIN, ST_MAC_ACC: ws_raddr = n_reg + 1'b1;
            default:                ws_raddr = n_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            ring_mem[seen_reg[WIN_AW-1:0]] <= s_tdata;
        ring_q_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ws_we)
            ws_mem[n_reg] <= ws_wdata;
        ws_q_reg <= ws_mem[ws_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            overlap_reg <= OVERLAP_RESET;
        else if (cfg_we)
            overlap_reg <= pwdata[OVL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            nfs_reg       <= '0;
            frames_reg    <= '0;
            eos_reg       <= 1'b0;
            fcnt_reg      <= '0;
            tail_reg      <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            nfs_reg       <= nfs_next;
            frames_reg    <= frames_next;
            eos_reg       <= eos_next;
            fcnt_reg      <= fcnt_next;
            tail_reg      <= tail_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avail_reg    <= avail_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        idx_reg      <= idx_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        prod_reg     <= prod_next;
        wprod_reg    <= wprod_next;
        re_abs_reg   <= re_abs_next;
        im_abs_reg   <= im_abs_next;
        sq_re_reg    <= sq_re_next;
        sq_im_reg    <= sq_im_next;
        db_reg       <= db_next;
        ne_reg       <= ne_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        nfs_next       = nfs_reg;
        frames_next    = frames_reg;
        eos_next       = eos_reg;
        fcnt_next      = fcnt_reg;
        tail_next      = tail_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        avail_next     = avail_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        prod_next      = prod_reg;
        wprod_next     = wprod_reg;
        re_abs_next    = re_abs_reg;
        im_abs_next    = im_abs_reg;
        sq_re_next     = sq_re_reg;
        sq_im_next     = sq_im_reg;
        db_next        = db_reg;
        ne_next        = ne_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    seen_next  = seen_reg + 1'b1;
                    eos_next   = s_tlast;
                    fcnt_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (dist_ge_win)
                begin
                    tail_next  = 1'b0;
                    final_next = eos_reg && (hop == dist7);
                    avail_next = dist7;
                    n_next     = '0;
                    state_next = ST_WIN_RD;
                end
                else
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (!eos_reg)
                    state_next = ST_IDLE;
                else if ((lag == '0) || dist_ge_win || (fcnt_reg == 2'd2))
                    state_next = ST_FINISH;
                else
                begin
                    tail_next  = 1'b1;
                    final_next = (hop >= dist7) || (fcnt_reg == 2'd1);
                    avail_next = dist7;
                    n_next     = '0;
                    state_next = ST_WIN_RD;
                end
            end
            ST_WIN_RD:
                state_next = ST_WIN_MUL;
            ST_WIN_MUL:
            begin
                wprod_next = $signed(ring_q_reg) * $signed(HANN_TAB[n_reg]);
                state_next = ST_WIN_WR;
            end
            ST_WIN_WR:
            begin
                n_next = n_reg + 1'b1;
                if (n_reg == WIN_AW'(WIN_LEN - 1))
                begin
                    k_next     = '0;
                    state_next = ST_BIN;
                end
                else
                    state_next = ST_WIN_RD;
            end
            ST_BIN:
            begin
                n_next      = '0;
                idx_next    = '0;
                acc_re_next = '0;
                acc_im_next = '0;
                state_next  = ST_MAC_COS;
            end
            ST_MAC_COS:
            begin
                prod_next  = $signed(ws_q_reg) * $signed(COS_TAB[idx_reg]);
                state_next = ST_MAC_SIN;
            end
            ST_MAC_SIN:
            begin
                acc_re_next = acc_re_reg + ACC_W'(prod_reg);
                prod_next   = $signed(ws_q_reg) * $signed(SIN_TAB[idx_reg]);
                state_next  = ST_MAC_ACC;
            end
            ST_MAC_ACC:
            begin
                acc_im_next = acc_im_reg - ACC_W'(prod_reg);
                idx_next    = idx_reg + WIN_AW'(k_reg);
                n_next      = n_reg + 1'b1;
                state_next  = (n_reg == WIN_AW'(WIN_LEN - 1)) ? ST_RND : ST_MAC_COS;
            end
            ST_RND:
            begin
                re_abs_next = re_mag[MAG_W-1:0];
                im_abs_next = im_mag[MAG_W-1:0];
                state_next  = ST_SQ_RE;
            end
            ST_SQ_RE:
            begin
                sq_re_next = PW'(re_abs_reg) * PW'(re_abs_reg);
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                sq_im_next = PW'(im_abs_reg) * PW'(im_abs_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
                state_next = ST_LOG;
            ST_LOG:
            begin
                if (log_done)
                begin
                    db_next    = log_db;
                    ne_next    = log_zero;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'd0, db_reg, 1'b0, k_reg, frames_reg};
                    out_last_next  = (k_reg == BIN_W'(NUM_BINS - 1));
                    out_user_next  = {(k_reg == BIN_W'(NUM_BINS - 1)) && final_reg, ne_reg};
                    if (k_reg == BIN_W'(NUM_BINS - 1))
                    begin
                        frames_next = frames_reg + 1'b1;
                        fcnt_next   = fcnt_reg + 1'b1;
                        if (tail_reg && (hop >= avail_reg))
                            state_next = ST_FINISH;
                        else
                        begin
                            nfs_next   = nfs_reg + 32'(hop);
                            state_next = ST_TAIL;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_BIN;
                    end
                end
            end
            ST_FINISH:
            begin
                seen_next   = '0;
                nfs_next    = '0;
                frames_next = '0;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    wfls_log2db u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (log_start),
        .power     (log_power),
        .done      (log_done),
        .db        (log_db),
        .no_energy (log_zero)
    );

endmodule

`default_nettype wire

// ----- rtl/wfls_checker.sv -----
// ---------------------------------------------------------------------------
// wfls_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "windowed_fft_log_spectrogram_assert.svh"

module wfls_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast,
    input wire [1:0]  m_tuser
);

    `WFLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `WFLS_ASSERT_SAME(a_sig_last_on_frame_last, m_tvalid && m_tuser[1], m_tlast)
    `WFLS_ASSERT_SAME(a_frame_last_bin, m_tvalid && m_tlast, m_tdata[21:16] == 6'd31)
    `WFLS_ASSERT_SAME(a_no_energy_zero_db, m_tvalid && m_tuser[0], m_tdata[36:22] == 15'd0)

endmodule

bind windowed_fft_log_spectrogram wfls_checker u_wfls_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// Testbench for windowed_fft_log_spectrogram
// Streams audio samples through the block, predicts every spectrum bin with
// an in-bench fixed-point STFT model and checks each result field by field.
// The overlap register is changed between phases, both handshakes stall at
// random, and one long output hold forces the block to stall its input.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
    import wfls_pkg::*;

    localparam int          BINS_PER_FRAME = (NUM_BINS < WIN_LEN) ? NUM_BINS : WIN_LEN;
    localparam int          RESULT_BUDGET  = 64;
    localparam logic [2:0]  OVERLAP_ADDR   = 3'(4 * REG_OVERLAP);
    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          SETTLE_CYCLES  = 50;

    typedef struct packed {
        logic [15:0] frame;
        logic [5:0]  bin;
        logic [14:0] db;
        logic        no_energy;
        logic        frame_last;
        logic        signal_last;
    } spectrum_bin_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    windowed_fft_log_spectrogram DUT (.*);

    // spectrum model state
    shortint       ring [WIN_LEN];
    logic [31:0]   seen;
    logic [31:0]   next_start;
    logic [15:0]   frame_count;
    logic [5:0]    overlap;
    longint        win_q15 [WIN_LEN];
    longint        cos_q15 [WIN_LEN];
    longint        sin_q15 [WIN_LEN];
    spectrum_bin_t spectrum_q [$];

    int  mismatches;
    int  idle_cycles;
    int  hold_left;
    int  stall_left;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic longint rshift(input longint v, input int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip_q15(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // cos and sin of phase/2^32 turns, Q1.30
    task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint tx;
        longint atan_q [24];
        begin
            atan_q = '{536870912, 316933406, 167458908, 85004756, 42667340, 21354465,
                       10679837, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
            x = 652032875;
            y = 0;
            z = longint'(phase[29:0]);
            for (int k = 0; k < 24; k++)
            begin
                tx = x;
                if (z >= 0)
                begin
                    x = x - (y >>> k);
                    y = y + (tx >>> k);
                    z = z - atan_q[k];
                end
                else
                begin
                    x = x + (y >>> k);
                    y = y - (tx >>> k);
                    z = z + atan_q[k];
                end
            end
            case (phase[31:30])
                2'd0:    begin c = x;  s = y;  end
                2'd1:    begin c = -y; s = x;  end
                2'd2:    begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
        end
    endtask

    task automatic build_tables();
        longint c;
        longint s;
        logic [63:0] ph;
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                ph = ((64'(i) << 32) + 64'((WIN_LEN - 1) / 2)) / 64'(WIN_LEN - 1);
                rotate(ph[31:0], c, s);
                win_q15[i] = clip_q15(rshift((64'sd1 <<< 30) - c, 16));
                ph = ((64'(i) << 32) + 64'(WIN_LEN / 2)) / 64'(WIN_LEN);
                rotate(ph[31:0], c, s);
                cos_q15[i] = clip_q15(rshift(c, 15));
                sin_q15[i] = clip_q15(rshift(s, 15));
            end
        end
    endtask

    function automatic logic [14:0] power_db(input logic [63:0] p);
        int          e;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] db;
        begin
            e = 63;
            while (!p[e])
                e--;
            m = (e <= 30) ? (p << (30 - e)) : (p >> (e - 30));
            lg = 64'(e) << 16;
            for (int b = 15; b >= 0; b--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    lg = lg | (64'd1 << b);
                    m = m >> 1;
                end
            end
            db = (lg * 64'd50504453 + (64'd1 << 31)) >> 32;
            return (db > 32767) ? 15'd32767 : db[14:0];
        end
    endfunction

    function automatic logic [31:0] hop();
        return (overlap >= WIN_LEN) ? 32'd1 : 32'(WIN_LEN - overlap);
    endfunction

    task automatic emit_spectrum(input logic [31:0] start);
        longint        ws [WIN_LEN];
        longint        acc_re;
        longint        acc_im;
        longint        re;
        longint        im;
        logic [63:0]   p;
        logic [31:0]   pos;
        int            idx;
        spectrum_bin_t r;
        begin
            for (int n = 0; n < WIN_LEN; n++)
            begin
                pos = start + 32'(n);
                if (32'(n) < seen - start)
                    ws[n] = rshift(longint'(ring[pos[5:0]]) * win_q15[n], 15);
                else
                    ws[n] = 0;
            end
            for (int k = 0; k < BINS_PER_FRAME; k++)
            begin
                acc_re = 0;
                acc_im = 0;
                idx = 0;
                for (int n = 0; n < WIN_LEN; n++)
                begin
                    acc_re += ws[n] * cos_q15[idx];
                    acc_im -= ws[n] * sin_q15[idx];
                    idx = (idx + k) % WIN_LEN;
                end
                re = rshift(acc_re, 15);
                im = rshift(acc_im, 15);
                p = 64'(re * re + im * im);
                r.frame = frame_count;
                r.bin = 6'(k);
                r.db = (p != 0) ? power_db(p) : 15'd0;
                r.no_energy = (p == 0);
                r.frame_last = (k == BINS_PER_FRAME - 1);
                r.signal_last = 1'b0;
                spectrum_q = {spectrum_q, r};
            end
            frame_count++;
        end
    endtask

    task automatic predict_sample(input logic [15:0] sample, input logic eos);
        int          count;
        logic [31:0] d;
        logic [31:0] h;
        begin
            count = 0;
            ring[seen[5:0]] = shortint'(sample);
            seen++;
            if (seen - next_start >= WIN_LEN)
            begin
                emit_spectrum(next_start);
                count += BINS_PER_FRAME;
                next_start += hop();
            end
            if (eos)
            begin
                while (1)
                begin
                    d = seen - next_start;
                    h = hop();
                    if (d == 0 || d >= WIN_LEN)
                        break;
                    if (count + BINS_PER_FRAME > RESULT_BUDGET)
                        break;
                    emit_spectrum(next_start);
                    count += BINS_PER_FRAME;
                    if (h >= d)
                        break;
                    next_start += h;
                end
                if (count > 0)
                    spectrum_q[spectrum_q.size() - 1].signal_last = 1'b1;
                seen = 0;
                next_start = 0;
                frame_count = 0;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // result checker and output stall generator
    always @(posedge clk)
    begin
        spectrum_bin_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (spectrum_q.size() == 0)
                report("unexpected bin", 32'(m_tdata[21:16]), 0);
            else
            begin
                w = spectrum_q.pop_front();
                if (m_tdata[15:0] != w.frame)
                    report("frame_number", m_tdata[15:0], w.frame);
                if (m_tdata[21:16] != w.bin)
                    report("bin_index", m_tdata[21:16], w.bin);
                if (m_tdata[36:22] != w.db)
                    report("power_db", m_tdata[36:22], w.db);
                if (m_tdata[39:37] != 3'd0)
                    report("tdata pad", m_tdata[39:37], 0);
                if (m_tuser[0] != w.no_energy)
                    report("no_energy", m_tuser[0], w.no_energy);
                if (m_tlast != w.frame_last)
                    report("frame_last", m_tlast, w.frame_last);
                if (m_tuser[1] != w.signal_last)
                    report("signal_last", m_tuser[1], w.signal_last);
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                      : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("windowed_fft_log_spectrogram test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] sample, input logic eos);
        int gap;
        begin
            gap = 0;
            if (!quiet && $urandom_range(0, 2) == 0)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= sample;
            s_tlast <= eos;
            do
                @(posedge clk);
            while (!s_tready);
            predict_sample(sample, eos);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (spectrum_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= OVERLAP_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_overlap(input logic [5:0] value);
        logic [31:0] rd;
        begin
            drain();
            apb_access(1'b1, 32'(value), rd);
            overlap = value;
            apb_access(1'b0, 32'd0, rd);
            if (rd[5:0] != value)
                report("overlap readback", rd[5:0], value);
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'(($urandom_range(0, 1) ? -1 : 1)
                                * int'($urandom_range(0, 1 << $urandom_range(0, 14))));
        endcase
    endfunction

    task automatic test_overlap_reset();
        logic [31:0] rd;
        begin
            apb_access(1'b0, 32'd0, rd);
            if (rd[5:0] != OVERLAP_RESET)
                report("overlap reset", rd[5:0], OVERLAP_RESET);
        end
    endtask

    task automatic test_directed();
        set_overlap(6'd32);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        // silent signal: every bin has no energy
        send_sample(16'h0000, 1'b1);
        // hop of one: tail frames exceed the output budget
        set_overlap(6'd63);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'hFF00, 1'b1);
        set_overlap(6'd0);
        send_sample(16'h1234, 1'b1);
    endtask

    task automatic test_random_signals(input logic [5:0] ovl, input int items);
        int sent;
        int len;
        begin
            set_overlap(ovl);
            quiet = $urandom_range(0, 3) == 0;
            sent = 0;
            while (sent < items)
            begin
                len = $urandom_range(1, 12);
                for (int i = 1; i <= len; i++)
                    send_sample(pick_sample(), i == len);
                sent += len;
            end
            quiet = 1'b0;
        end
    endtask

    // overlap changes mid-signal; a long output hold backs up the input;
    // the signal ends exactly on a full frame with no tail left
    task automatic test_midsignal_change_with_hold();
        set_overlap(6'd40);
        for (int i = 0; i < 70; i++)
        begin
            if (i == 30)
                hold_left = 3000;
            send_sample(pick_sample(), 1'b0);
        end
        set_overlap(6'd0);
        for (int i = 0; i < 18; i++)
            send_sample(pick_sample(), i == 17);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_left = 0;
        stall_left = 0;
        quiet = 1'b0;
        seen = 0;
        next_start = 0;
        frame_count = 0;
        overlap = OVERLAP_RESET;
        build_tables();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_overlap_reset();
        test_directed();
        test_random_signals(6'd17, 10);
        test_random_signals(6'd63, 10);
        test_midsignal_change_with_hold();
        test_random_signals(6'($urandom_range(0, 63)), 10);
        test_random_signals(6'd48, 10);
        drain();

        if (mismatches == 0)
            $display("windowed_fft_log_spectrogram test passed");
        else
            $display("windowed_fft_log_spectrogram test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/wfls_pkg.sv
rtl/wfls_log2db.sv
rtl/windowed_fft_log_spectrogram.sv
rtl/wfls_checker.sv
sim/testbench.sv
